>>> src/bpsm_pkg.sv
// Shared types, codes and reset constants for the battery power state monitor.
// No dependencies.
package bpsm_pkg;

	localparam int unsigned SAMPLES_PER_READING_DEF = 16;

	localparam int unsigned ADC_W = 12;
	localparam int unsigned MV_W  = 16;
	localparam int unsigned PCT_W = 10;
	localparam int unsigned MHZ_W = 9;
	localparam int unsigned TO_W  = 32;
	localparam int unsigned SCL_W = 24;
	localparam int unsigned CFG_W = 32;
	localparam int unsigned IDX_W = 3;

	// request kinds
	localparam logic [1:0] KIND_TICK     = 2'd0;
	localparam logic [1:0] KIND_SAMPLE   = 2'd1;
	localparam logic [1:0] KIND_ACTIVITY = 2'd2;

	// register indexes
	localparam logic [IDX_W-1:0] CFG_USB_THR  = 3'd0;
	localparam logic [IDX_W-1:0] CFG_IDLE_TO  = 3'd1;
	localparam logic [IDX_W-1:0] CFG_MV_SCALE = 3'd2;
	localparam logic [IDX_W-1:0] CFG_ACT_MHZ  = 3'd3;
	localparam logic [IDX_W-1:0] CFG_IDLE_MHZ = 3'd4;

	localparam logic [MV_W-1:0]  RST_USB_THR  = 16'd4300;
	localparam logic [TO_W-1:0]  RST_IDLE_TO  = 32'd30000;
	localparam logic [SCL_W-1:0] RST_MV_SCALE = 24'd105633;
	localparam logic [MHZ_W-1:0] RST_ACT_MHZ  = 9'd240;
	localparam logic [MHZ_W-1:0] RST_IDLE_MHZ = 9'd80;

	// below this a reading counts as external supply (no battery present)
	localparam logic [MV_W-1:0] MV_NO_BATT = 16'd100;

	typedef enum logic [1:0] {
		MODE_INIT   = 2'd0,
		MODE_USB    = 2'd1,
		MODE_ACTIVE = 2'd2,
		MODE_IDLE   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [MV_W-1:0]  usb_thr;
		logic [TO_W-1:0]  idle_to;
		logic [SCL_W-1:0] mv_scale;
		logic [MHZ_W-1:0] act_mhz;
		logic [MHZ_W-1:0] idle_mhz;
	} cfg_t;

	// reading path result, values after the current request
	typedef struct packed {
		logic             done;
		logic [MV_W-1:0]  mv;
		logic             chg;
		logic [PCT_W-1:0] tenths;
		logic             ev;
	} rdg_t;

	// power state result, values after the current request
	typedef struct packed {
		mode_t            mode;
		logic [MHZ_W-1:0] mhz;
		logic             changed;
		logic             bev;
	} fsm_t;

endpackage

>>> src/battery_power_state_monitor.sv
// Battery power state monitor, top level: handshake, input and result registers,
// configuration registers. Depends on bpsm_pkg, bpsm_pre, bpsm_rdg, bpsm_fsm.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one request per transfer: kind selects
//    a 1 ms tick, an ADC sample (adc_raw) or a user activity event. Kind 3 is ignored.
//  - Output channel (out_valid/out_ready) returns exactly one result per request, in
//    order: power state, voltage, charge, charging flag, CPU clock and event flags.
//  - A request passes the input register, then the result register behind out_valid.
//    Throughput is one request per cycle while out_ready holds, set by the single
//    pass through the reading multiplier and the state update.
//  - A stalled receiver holds the result register; one more request can sit in the
//    input register, after which in_ready drops until out_ready returns.
//  - Every SAMPLES_PER_READING samples form one reading (average times mv_scale_q16).
//  - Configuration (cfg_we/cfg_index/cfg_data) writes are registered; write only
//    while no request is in flight.
//  - Reset (arst_n low) restores register defaults, mode initializing, clock
//    request zero and empty sample group; both channels come up empty.
module battery_power_state_monitor import bpsm_pkg::*; #(
	parameter int unsigned SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [ADC_W-1:0]  adc_raw,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        power_state,
	output logic [MV_W-1:0]   voltage_mv,
	output logic [PCT_W-1:0]  percent_tenths,
	output logic              charging,
	output logic [MHZ_W-1:0]  cpu_mhz,
	output logic              state_changed,
	output logic              battery_event,
	output logic              reading_done,
	// configuration write port
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int unsigned RW = $clog2(SAMPLES_PER_READING + 1);

	cfg_t              cfg_q;

	// input register
	logic              valid_s1;
	logic [1:0]        kind_s1;
	logic [ADC_W-1:0]  quo_s1;
	logic [RW-1:0]     rem_s1;

	// result register
	logic              out_valid_q;
	mode_t             ps_q;
	logic [MV_W-1:0]   mv_q;
	logic [PCT_W-1:0]  pct_q;
	logic              chg_q;
	logic [MHZ_W-1:0]  mhz_q;
	logic              chgd_q;
	logic              bev_q;
	logic              done_q;

	logic              adv;
	logic [ADC_W-1:0]  quo;
	logic [RW-1:0]     rem;
	rdg_t              rdg;
	fsm_t              fsm;

	// stage 1 moves into the result register whenever that slot is free or draining
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.usb_thr  <= RST_USB_THR;
			cfg_q.idle_to  <= RST_IDLE_TO;
			cfg_q.mv_scale <= RST_MV_SCALE;
			cfg_q.act_mhz  <= RST_ACT_MHZ;
			cfg_q.idle_mhz <= RST_IDLE_MHZ;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_USB_THR:  cfg_q.usb_thr  <= cfg_data[MV_W-1:0];
				CFG_IDLE_TO:  cfg_q.idle_to  <= cfg_data[TO_W-1:0];
				CFG_MV_SCALE: cfg_q.mv_scale <= cfg_data[SCL_W-1:0];
				CFG_ACT_MHZ:  cfg_q.act_mhz  <= cfg_data[MHZ_W-1:0];
				CFG_IDLE_MHZ: cfg_q.idle_mhz <= cfg_data[MHZ_W-1:0];
				default: begin
					// indexes past the register list are dropped
				end
			endcase
		end
	end

	// sample split by group size happens ahead of the input register
	bpsm_pre #(
		.SAMPLES_PER_READING(SAMPLES_PER_READING)
	) u_pre (
		.raw (adc_raw),
		.quo (quo),
		.rem (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			quo_s1  <= quo;
			rem_s1  <= rem;
		end
	end

	bpsm_rdg #(
		.SAMPLES_PER_READING(SAMPLES_PER_READING)
	) u_rdg (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.kind_s1 (kind_s1),
		.quo_s1  (quo_s1),
		.rem_s1  (rem_s1),
		.cfg     (cfg_q),
		.rdg     (rdg)
	);

	bpsm_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.kind_s1 (kind_s1),
		.rdg     (rdg),
		.cfg     (cfg_q),
		.fsm     (fsm)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ps_q   <= fsm.mode;
			mv_q   <= rdg.mv;
			pct_q  <= rdg.tenths;
			chg_q  <= rdg.chg;
			mhz_q  <= fsm.mhz;
			chgd_q <= fsm.changed;
			bev_q  <= fsm.bev;
			done_q <= rdg.done;
		end
	end

	assign out_valid      = out_valid_q;
	assign power_state    = ps_q;
	assign voltage_mv     = mv_q;
	assign percent_tenths = pct_q;
	assign charging       = chg_q;
	assign cpu_mhz        = mhz_q;
	assign state_changed  = chgd_q;
	assign battery_event  = bev_q;
	assign reading_done   = done_q;

	// a battery event only comes with a completed reading
	a_bev_needs_reading: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bev_q |-> done_q)
		else $error("battery event without completed reading");

	// no path leads back into initializing
	a_no_return_to_init: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ps_q == MODE_INIT |-> !chgd_q)
		else $error("state change into initializing");

	// activity never leaves the block idle
	a_activity_wakes: assert property (@(posedge clk) disable iff (!arst_n)
		adv && kind_s1 == KIND_ACTIVITY |=> ps_q != MODE_IDLE)
		else $error("idle after activity request");

	// a held request in stage 1 keeps its kind
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(kind_s1))
		else $error("stage 1 request lost while stalled");

endmodule

>>> src/bpsm_pre.sv
// Input-side split of one ADC sample into quotient and remainder by the group size.
// Depends on bpsm_pkg.
module bpsm_pre import bpsm_pkg::*; #(
	parameter int unsigned SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
) (
	input  logic [ADC_W-1:0]                           raw,
	output logic [ADC_W-1:0]                           quo,
	output logic [$clog2(SAMPLES_PER_READING+1)-1:0]   rem
);

	localparam int unsigned S   = SAMPLES_PER_READING;
	localparam int unsigned RW  = $clog2(S + 1);
	localparam int unsigned K   = ADC_W + $clog2(S);
	localparam int unsigned M   = ((1 << K) + S - 1) / S;
	localparam int unsigned MW  = K + 1;
	localparam int unsigned PW  = ADC_W + MW;
	localparam int unsigned QSW = ADC_W + $clog2(S + 1);

	logic [PW-1:0]  prod;
	logic [QSW-1:0] qs;
	logic [QSW-1:0] rfull;

	// reciprocal multiply, exact for all 12-bit inputs (constant coefficient)
	always_comb begin
		prod  = PW'(raw) * PW'(M);
		quo   = prod[K +: ADC_W];
		qs    = QSW'(quo) * QSW'(S);
		rfull = QSW'(raw) - qs;
		rem   = rfull[RW-1:0];
	end

endmodule

>>> src/bpsm_rdg.sv
// Sample accumulation, voltage scaling, charging flag and charge curve.
// Depends on bpsm_pkg.
module bpsm_rdg import bpsm_pkg::*; #(
	parameter int unsigned SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     adv,
	input  logic [1:0]                               kind_s1,
	input  logic [ADC_W-1:0]                         quo_s1,
	input  logic [$clog2(SAMPLES_PER_READING+1)-1:0] rem_s1,
	input  cfg_t                                     cfg,
	output rdg_t                                     rdg
);

	localparam int unsigned S  = SAMPLES_PER_READING;
	localparam int unsigned RW = $clog2(S + 1);
	localparam int unsigned CW = $clog2(S + 1);
	localparam int unsigned PW = ADC_W + SCL_W;

	localparam logic [MV_W-1:0] V_4200 = 16'd4200;
	localparam logic [MV_W-1:0] V_3800 = 16'd3800;
	localparam logic [MV_W-1:0] V_3700 = 16'd3700;
	localparam logic [MV_W-1:0] V_3500 = 16'd3500;
	localparam logic [MV_W-1:0] V_3300 = 16'd3300;
	localparam logic [MV_W-1:0] V_3000 = 16'd3000;
	localparam logic [MV_W-1:0] EV_MV  = 16'd50;

	// piecewise LiPo curve, mV to tenths of a percent
	function automatic logic [PCT_W-1:0] curve(input logic [MV_W-1:0] v);
		logic [MV_W-1:0] t;
		logic [19:0]     p;
		t = '0;
		p = '0;
		if (v >= V_4200) begin
			t = 16'd1000;
		end else if (v >= V_3800) begin
			t = v - 16'd3200;                 // both upper segments are slope one
		end else if (v >= V_3700) begin
			t = (v << 1) - 16'd7000;
		end else if (v >= V_3500) begin
			t = v - 16'd3300;
		end else if (v >= V_3300) begin
			t = 16'd100 + ((v - V_3300) >> 1);
		end else if (v >= V_3000) begin
			// divide by three: x * 683 >> 11 is exact for x below 300
			p = 20'(v - V_3000) * 20'd683;
			t = 16'(p >> 11);
		end
		return t[PCT_W-1:0];
	endfunction

	logic [ADC_W-1:0]  qacc_q;
	logic [RW-1:0]     racc_q;
	logic [CW-1:0]     cnt_q;
	logic [MV_W-1:0]   mv_q;
	logic              chg_q;
	logic [PCT_W-1:0]  pct_q;

	logic              is_smp;
	logic [RW:0]       rsum;
	logic              carry;
	logic [RW-1:0]     rnew;
	logic [ADC_W-1:0]  avg;
	logic [CW-1:0]     cnt_nxt;
	logic              done;
	logic [PW-1:0]     prod;
	logic [MV_W-1:0]   mv_new;
	logic              chg_new;
	logic [MV_W-1:0]   diff;

	always_comb begin
		is_smp  = (kind_s1 == KIND_SAMPLE);
		rsum    = (RW+1)'(racc_q) + (RW+1)'(rem_s1);
		carry   = (rsum >= (RW+1)'(S));
		rnew    = carry ? RW'(rsum - (RW+1)'(S)) : rsum[RW-1:0];
		avg     = qacc_q + quo_s1 + ADC_W'(carry);
		cnt_nxt = cnt_q + CW'(1);
		done    = is_smp && (cnt_nxt == CW'(S));
		prod    = PW'(avg) * PW'(cfg.mv_scale);
		mv_new  = (|prod[PW-1:32]) ? '1 : prod[31:16];
		chg_new = (mv_new > cfg.usb_thr);
		diff    = (mv_q > mv_new) ? (mv_q - mv_new) : (mv_new - mv_q);

		rdg.done   = done;
		rdg.mv     = done ? mv_new : mv_q;
		rdg.chg    = done ? chg_new : chg_q;
		rdg.tenths = done ? curve(mv_new) : pct_q;
		rdg.ev     = done && ((diff > EV_MV) || (chg_new != chg_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qacc_q <= '0;
			racc_q <= '0;
			cnt_q  <= '0;
			mv_q   <= '0;
			chg_q  <= 1'b0;
			pct_q  <= '0;
		end else if (adv && is_smp) begin
			if (done) begin
				qacc_q <= '0;
				racc_q <= '0;
				cnt_q  <= '0;
				mv_q   <= mv_new;
				chg_q  <= chg_new;
				pct_q  <= curve(mv_new);
			end else begin
				qacc_q <= avg;
				racc_q <= rnew;
				cnt_q  <= cnt_nxt;
			end
		end
	end

endmodule

>>> src/bpsm_fsm.sv
// Power state machine: mode, idle timer and requested CPU clock.
// Depends on bpsm_pkg.
module bpsm_fsm import bpsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [1:0] kind_s1,
	input  rdg_t       rdg,
	input  cfg_t       cfg,
	output fsm_t       fsm
);

	mode_t             mode_q;
	logic [TO_W-1:0]   idle_q;
	logic [MHZ_W-1:0]  mhz_q;

	mode_t             mode_n;
	logic [TO_W-1:0]   idle_n;
	logic [MHZ_W-1:0]  mhz_n;
	logic              usb_like;
	logic              counts;

	always_comb begin
		mode_n   = mode_q;
		idle_n   = idle_q;
		mhz_n    = mhz_q;
		usb_like = (rdg.mv > cfg.usb_thr) || (rdg.mv < MV_NO_BATT);
		counts   = 1'b0;
		fsm.bev  = 1'b0;

		unique case (kind_s1)
			KIND_TICK: begin
				counts = 1'b1;
				if (idle_q != '1) begin
					idle_n = idle_q + TO_W'(1);
				end
			end
			KIND_SAMPLE: begin
				counts = 1'b1;
				if (rdg.done) begin
					if (mode_q == MODE_INIT) begin
						mhz_n  = cfg.act_mhz;
						idle_n = '0;
						mode_n = usb_like ? MODE_USB : MODE_ACTIVE;
					end else begin
						fsm.bev = rdg.ev;
						if (usb_like && mode_q != MODE_USB) begin
							mode_n = MODE_USB;
							mhz_n  = cfg.act_mhz;
						end else if (!usb_like && mode_q == MODE_USB) begin
							mode_n = MODE_ACTIVE;
							idle_n = '0;
						end
					end
				end
			end
			KIND_ACTIVITY: begin
				idle_n = '0;
				if (mode_q == MODE_IDLE) begin
					mode_n = MODE_ACTIVE;
					mhz_n  = cfg.act_mhz;
				end
			end
			default: begin
				// unused kind: no change
			end
		endcase

		// timeout check runs after any reading update
		if (counts && mode_n == MODE_ACTIVE && idle_n >= cfg.idle_to) begin
			mode_n = MODE_IDLE;
			mhz_n  = cfg.idle_mhz;
		end

		fsm.mode    = mode_n;
		fsm.mhz     = mhz_n;
		fsm.changed = (mode_n != mode_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_INIT;
			idle_q <= '0;
			mhz_q  <= '0;
		end else if (adv) begin
			mode_q <= mode_n;
			idle_q <= idle_n;
			mhz_q  <= mhz_n;
		end
	end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for battery_power_state_monitor: directed table, then random phases.
// Depends on bpsm_pkg and the RTL top level; carries its own cycle-free model of the monitor.
module testbench;
	import bpsm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SPR = SAMPLES_PER_READING_DEF;
	// kind 3 has no meaning; the block must ignore it
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int unsigned PHASE_ITEMS = 265;
	localparam int unsigned DIR_ROWS = 22;

	// one result of the block, field for field
	typedef struct packed {
		mode_t            st;
		logic [MV_W-1:0]  mv;
		logic [PCT_W-1:0] pct;
		logic             chg;
		logic [MHZ_W-1:0] mhz;
		logic             changed;
		logic             bev;
		logic             done;
	} monitor_status_t;

	// directed row: request plus, where obvious, the typed-in result
	typedef struct packed {
		logic [1:0]      k;
		logic [ADC_W-1:0] raw;
		logic            typed;
		monitor_status_t want;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        kind = KIND_TICK;
	logic [ADC_W-1:0]  adc_raw = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        power_state;
	logic [MV_W-1:0]   voltage_mv;
	logic [PCT_W-1:0]  percent_tenths;
	logic              charging;
	logic [MHZ_W-1:0]  cpu_mhz;
	logic              state_changed;
	logic              battery_event;
	logic              reading_done;
	logic              cfg_we = 1'b0;
	logic [IDX_W-1:0]  cfg_index = CFG_USB_THR;
	logic [CFG_W-1:0]  cfg_data = '0;

	battery_power_state_monitor i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.adc_raw        (adc_raw),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.power_state    (power_state),
		.voltage_mv     (voltage_mv),
		.percent_tenths (percent_tenths),
		.charging       (charging),
		.cpu_mhz        (cpu_mhz),
		.state_changed  (state_changed),
		.battery_event  (battery_event),
		.reading_done   (reading_done),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Monitor model: register copy and state, advanced once per request
	// ------------------------------------------------------------------
	cfg_t             cfg_copy;
	mode_t            cur_mode;
	int unsigned      grp_sum;
	int unsigned      grp_cnt;
	logic [MV_W-1:0]  mv_now;
	logic [PCT_W-1:0] tenths_now;
	logic             chg_now;
	logic [TO_W-1:0]  idle_ms;
	logic [MHZ_W-1:0] mhz_now;

	monitor_status_t  status_due [$];   // results owed by the block, oldest first
	int unsigned      errors = 0;
	bit               quiet = 1'b0;     // no idling on either side while set

	// piecewise LiPo discharge curve, mV to tenths of a percent
	function automatic logic [PCT_W-1:0] tenths_of(input logic [MV_W-1:0] v);
		int unsigned x;
		int unsigned t;
		x = v;
		if (x >= 4200)      t = 1000;
		else if (x >= 4000) t = 800 + (x - 4000);
		else if (x >= 3800) t = 600 + (x - 3800);
		else if (x >= 3700) t = 400 + (x - 3700) * 2;
		else if (x >= 3500) t = 200 + (x - 3500);
		else if (x >= 3300) t = 100 + (x - 3300) / 2;
		else if (x >= 3000) t = (x - 3000) / 3;
		else                t = 0;
		return t[PCT_W-1:0];
	endfunction

	function automatic monitor_status_t advance_monitor(input logic [1:0] k,
			input logic [ADC_W-1:0] raw);
		monitor_status_t r;
		mode_t           mode0;
		logic [35:0]     prod;
		logic [ADC_W-1:0] avg;
		logic [MV_W-1:0] mv_old;
		logic            chg_old;
		logic [MV_W-1:0] dv;
		logic            supply;
		r = '0;
		mode0 = cur_mode;
		case (k)
			KIND_TICK: begin
				if (idle_ms != '1) idle_ms = idle_ms + 1'b1;
			end
			KIND_SAMPLE: begin
				grp_sum = grp_sum + raw;
				grp_cnt = grp_cnt + 1;
				if (grp_cnt >= SPR) begin
					avg = ADC_W'(grp_sum / SPR);
					prod = 36'(avg) * 36'(cfg_copy.mv_scale);
					mv_old = mv_now;
					chg_old = chg_now;
					grp_sum = 0;
					grp_cnt = 0;
					r.done = 1'b1;
					mv_now = (prod[35:16] > 20'd65535) ? 16'hFFFF : prod[31:16];
					chg_now = mv_now > cfg_copy.usb_thr;
					tenths_now = tenths_of(mv_now);
					// above threshold, or no battery at all
					supply = chg_now || (mv_now < MV_NO_BATT);
					if (cur_mode == MODE_INIT) begin
						mhz_now = cfg_copy.act_mhz;
						idle_ms = '0;
						cur_mode = supply ? MODE_USB : MODE_ACTIVE;
					end else begin
						if (supply && cur_mode != MODE_USB) begin
							cur_mode = MODE_USB;
							mhz_now = cfg_copy.act_mhz;
						end else if (!supply && cur_mode == MODE_USB) begin
							cur_mode = MODE_ACTIVE;
							idle_ms = '0;
						end
						dv = (mv_old > mv_now) ? mv_old - mv_now : mv_now - mv_old;
						r.bev = (dv > 16'd50) || (chg_old != chg_now);
					end
				end
			end
			KIND_ACTIVITY: begin
				idle_ms = '0;
				if (cur_mode == MODE_IDLE) begin
					mhz_now = cfg_copy.act_mhz;
					cur_mode = MODE_ACTIVE;
				end
			end
			default: ;
		endcase
		// idle timeout, checked after any reading update
		if ((k == KIND_TICK || k == KIND_SAMPLE) && cur_mode == MODE_ACTIVE &&
				idle_ms >= cfg_copy.idle_to) begin
			mhz_now = cfg_copy.idle_mhz;
			cur_mode = MODE_IDLE;
		end
		r.st = cur_mode;
		r.mv = mv_now;
		r.pct = tenths_now;
		r.chg = chg_now;
		r.mhz = mhz_now;
		r.changed = (cur_mode != mode0);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 40) $display("%0t mismatch: %s", $realtime, what);
	endtask

	// ------------------------------------------------------------------
	// Result side: random backpressure and in-order comparison
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_ready <= quiet || ($urandom_range(0, 99) >= 14);
	end

	always @(posedge clk) begin
		monitor_status_t got;
		monitor_status_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{mode_t'(power_state), voltage_mv, percent_tenths, charging, cpu_mhz,
				state_changed, battery_event, reading_done};
			if (status_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing owed: %p", got));
			end else begin
				want = status_due.pop_front();
				if (got !== want)
					report_mismatch($sformatf("got %p want %p", got, want));
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	// Holds the request until accepted; returns in the step of the accepting edge
	// with in_valid still high, so the caller decides the next value exactly once.
	task automatic send_req(input logic [1:0] k, input logic [ADC_W-1:0] raw,
			input logic typed, input monitor_status_t want);
		monitor_status_t pred;
		while (!quiet && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		adc_raw <= raw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = advance_monitor(k, raw);
		status_due.push_back(typed ? want : pred);
	endtask

	// stop sending and let every owed result come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (status_due.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_USB_THR:  cfg_copy.usb_thr  = val[MV_W-1:0];
			CFG_IDLE_TO:  cfg_copy.idle_to  = val[TO_W-1:0];
			CFG_MV_SCALE: cfg_copy.mv_scale = val[SCL_W-1:0];
			CFG_ACT_MHZ:  cfg_copy.act_mhz  = val[MHZ_W-1:0];
			CFG_IDLE_MHZ: cfg_copy.idle_mhz = val[MHZ_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input cfg_t c);
		write_reg(CFG_USB_THR,  CFG_W'(c.usb_thr));
		write_reg(CFG_IDLE_TO,  CFG_W'(c.idle_to));
		write_reg(CFG_MV_SCALE, CFG_W'(c.mv_scale));
		write_reg(CFG_ACT_MHZ,  CFG_W'(c.act_mhz));
		write_reg(CFG_IDLE_MHZ, CFG_W'(c.idle_mhz));
		cfg_we <= 1'b0;
	endtask

	// random request generator; samples come in groups around one level so that
	// readings land in the battery band and walk the state machine
	logic [ADC_W-1:0] grp_level;
	int unsigned      gen_left = 0;

	task automatic next_random(output logic [1:0] k, output logic [ADC_W-1:0] raw);
		int unsigned sel;
		int          v;
		sel = $urandom_range(0, 99);
		raw = ADC_W'($urandom);
		if (sel < 60) begin
			k = KIND_SAMPLE;
			if (gen_left == 0) begin
				sel = $urandom_range(0, 99);
				if (sel < 55)      grp_level = ADC_W'($urandom_range(1700, 2800));
				else if (sel < 70) grp_level = ADC_W'($urandom_range(2800, 4095));
				else if (sel < 85) grp_level = ADC_W'($urandom_range(0, 60));
				else               grp_level = ADC_W'($urandom);
				gen_left = SPR;
			end
			gen_left--;
			// a few wild samples inside a group, otherwise small jitter
			if ($urandom_range(0, 99) >= 5) begin
				v = int'(grp_level) + $urandom_range(0, 16) - 8;
				if (v < 0) v = 0;
				if (v > 4095) v = 4095;
				raw = ADC_W'(v);
			end
		end else if (sel < 88) begin
			k = KIND_TICK;
		end else if (sel < 96) begin
			k = KIND_ACTIVITY;
		end else begin
			k = KIND_UNUSED;
		end
	endtask

	function automatic monitor_status_t status(input mode_t st, input int mv, input int pct,
			input bit chg, input int mhz, input bit sc, input bit be, input bit rd);
		return '{st, MV_W'(mv), PCT_W'(pct), chg, MHZ_W'(mhz), sc, be, rd};
	endfunction

	function automatic dir_row_t row(input logic [1:0] k, input logic [ADC_W-1:0] raw,
			input logic typed, input monitor_status_t want);
		return '{k, raw, typed, want};
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		dir_row_t        dir_tab [DIR_ROWS];
		cfg_t            phase_cfg;
		logic [1:0]      rk;
		logic [ADC_W-1:0] rraw;

		cfg_copy = '{RST_USB_THR, RST_IDLE_TO, RST_MV_SCALE, RST_ACT_MHZ, RST_IDLE_MHZ};
		cur_mode = MODE_INIT;
		grp_sum = 0;
		grp_cnt = 0;
		mv_now = '0;
		tenths_now = '0;
		chg_now = 1'b0;
		idle_ms = '0;
		mhz_now = '0;

		// after reset nothing is known: clock request 0, no reading; a full-scale
		// group is the first reading and lands far above the USB threshold
		dir_tab = '{
			row(KIND_TICK,     12'h000, 1'b1, status(MODE_INIT, 0, 0, 0, 0, 0, 0, 0)),
			row(KIND_UNUSED,   12'hFFF, 1'b1, status(MODE_INIT, 0, 0, 0, 0, 0, 0, 0)),
			row(KIND_ACTIVITY, 12'h000, 1'b1, status(MODE_INIT, 0, 0, 0, 0, 0, 0, 0)),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b0, '0),
			row(KIND_SAMPLE,   12'hFFF, 1'b1,
				status(MODE_USB, 6600, 1000, 1, 240, 1, 0, 1)),
			row(KIND_TICK,     12'hFFF, 1'b0, '0),
			row(KIND_UNUSED,   12'h000, 1'b1,
				status(MODE_USB, 6600, 1000, 1, 240, 0, 0, 0)),
			row(KIND_ACTIVITY, 12'hFFF, 1'b0, '0)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_req(dir_tab[i].k, dir_tab[i].raw, dir_tab[i].typed, dir_tab[i].want);

		// phase 0 keeps reset values; later phases rewrite every register
		for (int ph = 0; ph < 7; ph++) begin
			if (ph != 0) begin
				drain_results();
				case (ph)
					// saturating scale, everything counts as USB, instant timeout
					1: phase_cfg = '{16'd0, 32'd0, 24'hFFFFFF, 9'd511, 9'd1};
					// zero scale, threshold and timeout at their tops
					2: phase_cfg = '{16'hFFFF, 32'hFFFFFFFF, 24'd0, 9'd1, 9'd511};
					3: phase_cfg = '{16'd4300, 32'd25, 24'd105633, 9'd240, 9'd80};
					4: phase_cfg = '{MV_W'($urandom_range(3000, 5000)),
						TO_W'($urandom_range(0, 60)), SCL_W'($urandom_range(60000, 150000)),
						MHZ_W'($urandom_range(1, 511)), MHZ_W'($urandom_range(1, 511))};
					5: phase_cfg = '{MV_W'($urandom), TO_W'($urandom_range(0, 200)),
						SCL_W'($urandom), MHZ_W'($urandom_range(1, 511)),
						MHZ_W'($urandom_range(1, 511))};
					default: phase_cfg = '{16'd4100, 32'd1, 24'd105633, 9'd200, 9'd100};
				endcase
				write_all(phase_cfg);
			end
			// one phase runs with no idling at all on either side
			quiet = (ph == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// sender holds off until the block has returned everything
				if (n == 130) drain_results();
				next_random(rk, rraw);
				send_req(rk, rraw, 1'b0, '0);
			end
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		for (int w = 0; w < 2000 && status_due.size() != 0; w++) @(posedge clk);
		repeat (4) @(posedge clk);
		if (status_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", status_due.size()));

		if (errors == 0) begin
			$display("[battery_power_state_monitor] OK");
		end else begin
			$display("[battery_power_state_monitor] ERROR");
		end
		$finish;
	end

	// watchdog: ends a run that never finishes
	initial begin
		#2000000;
		$display("[battery_power_state_monitor] ERROR");
		$finish;
	end

endmodule
